>>> rtl/tmb_pkg.sv
// Shared types and constants of the trimmed mean 3x3 blur.
`default_nettype none

package tmb_pkg;

   localparam int MAX_DIM_DEF = 1024;
   localparam int DIM_RESET   = 1024;
   localparam int DIM_MIN     = 3;
   localparam int CSR_W       = 11;
   localparam int CHAN_W      = 8;
   localparam int POS_OUT_W   = 10;
   localparam int LUMA_W      = 10;
   localparam int SUM_W       = 12;
   localparam int TRIM_W      = 11;
   localparam int WIN_N       = 9;
   localparam int RECIP_W     = 16;
   localparam int RECIP_SHIFT = 18;
   localparam logic [RECIP_W-1:0] RECIP_7 = 16'd37450;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_type;

   typedef struct packed {
      pixel_type above;
      pixel_type two_above;
   } line_type;

   typedef struct packed {
      logic [POS_OUT_W-1:0] row;
      logic [POS_OUT_W-1:0] col;
      logic                 done;
   } meta_type;

   typedef pixel_type [WIN_N-1:0] window_type;

endpackage

`default_nettype wire

>>> rtl/tmb_ram.sv
// Generic single-clock RAM, one write port, one registered read port.
`default_nettype none

module tmb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/tmb_window.sv
// Line store read-modify-write stage and 3x3 window columns.
`default_nettype none

module tmb_window #(
   parameter int MAX_DIM = tmb_pkg::MAX_DIM_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  tmb_pkg::pixel_type         in_pix,
   input  logic [$clog2(MAX_DIM)-1:0] in_addr,
   input  logic                       in_emit,
   input  tmb_pkg::meta_type          in_meta,
   output logic                       out_valid,
   input  logic                       out_ready,
   output tmb_pkg::window_type        out_win,
   output tmb_pkg::meta_type          out_meta
);

   import tmb_pkg::*;

   localparam int ADDR_W = $clog2(MAX_DIM);

   logic              s1_valid_ff;
   logic              emit_ff;
   pixel_type         pix_ff;
   logic [ADDR_W-1:0] addr_ff;
   meta_type          meta_ff;
   logic              fwd_ff;
   logic              fwd_in;
   line_type          fwd_line_ff;
   line_type          rd_line;
   line_type          line_use;
   line_type          wr_line;
   pixel_type         col0_ff [3];
   pixel_type         col1_ff [3];
   pixel_type         cur [3];
   logic              advance;
   logic              load;

   assign advance   = s1_valid_ff && (!emit_ff || out_ready);
   assign in_ready  = !s1_valid_ff || advance;
   assign load      = in_valid && in_ready;
   assign out_valid = s1_valid_ff && emit_ff;
   assign out_meta  = meta_ff;

   // entry written by the word ahead in the same cycle as our read
   assign fwd_in   = advance && (addr_ff == in_addr);
   assign line_use = fwd_ff ? fwd_line_ff : rd_line;

   always_comb begin
      cur[0]            = line_use.two_above;
      cur[1]            = line_use.above;
      cur[2]            = pix_ff;
      wr_line.above     = pix_ff;
      wr_line.two_above = line_use.above;
      for (int i = 0; i < 3; i++) begin
         out_win[i*3]     = col0_ff[i];
         out_win[i*3 + 1] = col1_ff[i];
         out_win[i*3 + 2] = cur[i];
      end
   end

   tmb_ram #(
      .WIDTH ($bits(line_type)),
      .DEPTH (MAX_DIM)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (advance),
      .wr_addr (addr_ff),
      .wr_data (wr_line),
      .rd_en   (load),
      .rd_addr (in_addr),
      .rd_data (rd_line)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         if (in_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (load) begin
            fwd_ff <= fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff      <= in_pix;
         addr_ff     <= in_addr;
         emit_ff     <= in_emit;
         meta_ff     <= in_meta;
         fwd_line_ff <= wr_line;
      end
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            col0_ff[i] <= col1_ff[i];
            col1_ff[i] <= cur[i];
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/tmb_kernel.sv
// Trimmed sum, min/max rejection and divide-by-seven pipeline.
`default_nettype none

module tmb_kernel (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  tmb_pkg::window_type in_win,
   input  tmb_pkg::meta_type   in_meta,
   output logic                out_valid,
   input  logic                out_ready,
   output tmb_pkg::pixel_type  out_pix,
   output tmb_pkg::meta_type   out_meta
);

   import tmb_pkg::*;

   localparam int PROD_W = TRIM_W + RECIP_W;

   function automatic logic [LUMA_W-1:0] intensity(input pixel_type p);
      return LUMA_W'(p.red) + LUMA_W'(p.green) + LUMA_W'(p.blue);
   endfunction

   // floor(t/7) for t below 7*256
   function automatic logic [CHAN_W-1:0] div7(input logic [TRIM_W-1:0] t);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(t) * PROD_W'(RECIP_7);
      return prod[RECIP_SHIFT +: CHAN_W];
   endfunction

   logic s2_valid_ff, s3_valid_ff, s4_valid_ff, out_valid_ff;
   logic s2_adv, s3_adv, s4_adv;
   logic s3_free, s4_free, out_free;

   window_type        win_ff;
   meta_type          meta2_ff, meta3_ff, meta4_ff, out_meta_ff;
   logic [SUM_W-1:0]  sum_red_in, sum_green_in, sum_blue_in;
   logic [SUM_W-1:0]  sum_red_ff, sum_green_ff, sum_blue_ff;
   pixel_type         lo_in, hi_in, lo_ff, hi_ff;
   logic [TRIM_W-1:0] trim_red_in, trim_green_in, trim_blue_in;
   logic [TRIM_W-1:0] trim_red_ff, trim_green_ff, trim_blue_ff;
   pixel_type         out_pix_in, out_pix_ff;

   assign out_free = !out_valid_ff || out_ready;
   assign s4_adv   = s4_valid_ff && out_free;
   assign s4_free  = !s4_valid_ff || s4_adv;
   assign s3_adv   = s3_valid_ff && s4_free;
   assign s3_free  = !s3_valid_ff || s3_adv;
   assign s2_adv   = s2_valid_ff && s3_free;
   assign in_ready = !s2_valid_ff || s2_adv;

   assign out_valid = out_valid_ff;
   assign out_pix   = out_pix_ff;
   assign out_meta  = out_meta_ff;

   // min: last on ties; max: first on ties
   always_comb begin
      logic [LUMA_W-1:0] v;
      logic [LUMA_W-1:0] lo_v;
      logic [LUMA_W-1:0] hi_v;
      lo_v         = '0;
      hi_v         = '0;
      lo_in        = win_ff[0];
      hi_in        = win_ff[0];
      sum_red_in   = '0;
      sum_green_in = '0;
      sum_blue_in  = '0;
      for (int k = 0; k < WIN_N; k++) begin
         v            = intensity(win_ff[k]);
         sum_red_in   = sum_red_in + SUM_W'(win_ff[k].red);
         sum_green_in = sum_green_in + SUM_W'(win_ff[k].green);
         sum_blue_in  = sum_blue_in + SUM_W'(win_ff[k].blue);
         if (k == 0 || v <= lo_v) begin
            lo_v  = v;
            lo_in = win_ff[k];
         end
         if (k == 0 || v > hi_v) begin
            hi_v  = v;
            hi_in = win_ff[k];
         end
      end
   end

   always_comb begin
      trim_red_in   = TRIM_W'(sum_red_ff - SUM_W'(lo_ff.red) - SUM_W'(hi_ff.red));
      trim_green_in = TRIM_W'(sum_green_ff - SUM_W'(lo_ff.green) - SUM_W'(hi_ff.green));
      trim_blue_in  = TRIM_W'(sum_blue_ff - SUM_W'(lo_ff.blue) - SUM_W'(hi_ff.blue));
      out_pix_in.red   = div7(trim_red_ff);
      out_pix_in.green = div7(trim_green_ff);
      out_pix_in.blue  = div7(trim_blue_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            s2_valid_ff <= in_valid;
         end
         if (s3_free) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_free) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (out_free) begin
            out_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         win_ff   <= in_win;
         meta2_ff <= in_meta;
      end
      if (s2_adv) begin
         sum_red_ff   <= sum_red_in;
         sum_green_ff <= sum_green_in;
         sum_blue_ff  <= sum_blue_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         meta3_ff     <= meta2_ff;
      end
      if (s3_adv) begin
         trim_red_ff   <= trim_red_in;
         trim_green_ff <= trim_green_in;
         trim_blue_ff  <= trim_blue_in;
         meta4_ff      <= meta3_ff;
      end
      if (s4_adv) begin
         out_pix_ff  <= out_pix_in;
         out_meta_ff <= meta4_ff;
      end
   end

endmodule

`default_nettype wire

>>> rtl/trimmed_mean_blur_3x3.sv
// A result word passes the window stage register and the kernel window, sum, trim and output registers.
// Throughput: one pixel word per cycle unless rsp_ready stalls; line store RAM read and written once per word.
// Border pixels give no result word; interior pixels give one each, in raster order.
// Reset clears the pipeline valids, the row/column position and sets image_dim to 1024 (at most MAX_DIM).
// The line stores and window columns are not cleared; there is no clearing pass.
`default_nettype none

module trimmed_mean_blur_3x3 #(
   parameter int MAX_DIM = tmb_pkg::MAX_DIM_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tmb_pkg::CHAN_W-1:0]      req_pix_red,
   input  logic [tmb_pkg::CHAN_W-1:0]      req_pix_green,
   input  logic [tmb_pkg::CHAN_W-1:0]      req_pix_blue,
   input  logic                            req_frame_start,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tmb_pkg::POS_OUT_W-1:0]   rsp_out_row,
   output logic [tmb_pkg::POS_OUT_W-1:0]   rsp_out_col,
   output logic [tmb_pkg::CHAN_W-1:0]      rsp_out_red,
   output logic [tmb_pkg::CHAN_W-1:0]      rsp_out_green,
   output logic [tmb_pkg::CHAN_W-1:0]      rsp_out_blue,
   output logic                            rsp_frame_done,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tmb_pkg::CSR_W-1:0]       csr_image_dim
);

   import tmb_pkg::*;

   localparam int POS_W = $clog2(MAX_DIM);
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int EXT_W = ((DIM_W > CSR_W) ? DIM_W : CSR_W) + 1;
   localparam int DIM_RST_EFF = (DIM_RESET > MAX_DIM) ? MAX_DIM : DIM_RESET;
   localparam logic [POS_W-1:0] DIM_LAST_RST = POS_W'(DIM_RST_EFF - 1);

   logic [POS_W-1:0] dim_last_ff, dim_last_in;
   logic [EXT_W-1:0] dim_ext, dim_sel;
   logic [POS_W-1:0] row_ff, col_ff, row_in, col_in;
   logic [POS_W-1:0] r, c;
   logic             accept;
   logic             emit;
   pixel_type        pix;
   meta_type         meta;
   logic             win_valid, win_ready;
   window_type       win;
   meta_type         win_meta;
   pixel_type        out_pix;
   meta_type         out_meta;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;

   // clamp the written size into [3, MAX_DIM]
   always_comb begin
      dim_ext = EXT_W'(csr_image_dim);
      if (dim_ext < EXT_W'(DIM_MIN)) begin
         dim_sel = EXT_W'(DIM_MIN);
      end else if (dim_ext > EXT_W'(MAX_DIM)) begin
         dim_sel = EXT_W'(MAX_DIM);
      end else begin
         dim_sel = dim_ext;
      end
      dim_last_in = POS_W'(dim_sel - EXT_W'(1));
   end

   always_comb begin
      r = req_frame_start ? '0 : row_ff;
      c = req_frame_start ? '0 : col_ff;
      emit = (r >= POS_W'(2)) && (c >= POS_W'(2)) && (r <= dim_last_ff) && (c <= dim_last_ff);
      meta.row  = POS_OUT_W'(r - POS_W'(1));
      meta.col  = POS_OUT_W'(c - POS_W'(1));
      meta.done = (r == dim_last_ff) && (c == dim_last_ff);
      if (c >= dim_last_ff) begin
         col_in = '0;
         row_in = (r >= dim_last_ff) ? '0 : r + POS_W'(1);
      end else begin
         col_in = c + POS_W'(1);
         row_in = r;
      end
      pix.red   = req_pix_red;
      pix.green = req_pix_green;
      pix.blue  = req_pix_blue;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_last_ff <= DIM_LAST_RST;
         row_ff      <= '0;
         col_ff      <= '0;
      end else begin
         if (csr_valid) begin
            dim_last_ff <= dim_last_in;
         end
         if (accept) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
      end
   end

   tmb_window #(
      .MAX_DIM (MAX_DIM)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_pix    (pix),
      .in_addr   (c),
      .in_emit   (emit),
      .in_meta   (meta),
      .out_valid (win_valid),
      .out_ready (win_ready),
      .out_win   (win),
      .out_meta  (win_meta)
   );

   tmb_kernel u_kernel (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (win_valid),
      .in_ready  (win_ready),
      .in_win    (win),
      .in_meta   (win_meta),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_pix   (out_pix),
      .out_meta  (out_meta)
   );

   assign rsp_out_row    = out_meta.row;
   assign rsp_out_col    = out_meta.col;
   assign rsp_frame_done = out_meta.done;
   assign rsp_out_red    = out_pix.red;
   assign rsp_out_green  = out_pix.green;
   assign rsp_out_blue   = out_pix.blue;

`ifndef SYNTHESIS
   a_reset_flush: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid right after reset");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_frame_start |=> (row_ff == '0) && (col_ff == POS_W'(1)))
      else $error("frame start did not restart the position");

   a_done_on_diagonal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_out_row == rsp_out_col)
      else $error("frame done off the last interior pixel");
`endif

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the trimmed mean 3x3 blur: random raster streams against a predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tmb_pkg::*;

   localparam int MAX_DIM     = MAX_DIM_DEF;
   localparam int QUIET_LIMIT = 1000;
   localparam int RAND_WORDS  = 200;

   typedef struct packed {
      logic [POS_OUT_W-1:0] row;
      logic [POS_OUT_W-1:0] col;
      logic [CHAN_W-1:0]    red;
      logic [CHAN_W-1:0]    green;
      logic [CHAN_W-1:0]    blue;
      logic                 done;
   } blur_word_type;

   typedef enum int {RUN_FRAMES, RUN_RESTART, RUN_CONTINUE, RUN_NOISY} run_kind_type;

   class blur_scoreboard;
      pixel_type        above_row[MAX_DIM];
      pixel_type        two_above_row[MAX_DIM];
      pixel_type        prev_cols[2][3];
      int unsigned      row_pos;
      int unsigned      col_pos;
      logic [CSR_W-1:0] dim_reg;
      blur_word_type    pending[$];
      int unsigned      errors;
      int unsigned      checked;
      int unsigned      frames_done;

      function new();
         row_pos     = 0;
         col_pos     = 0;
         dim_reg     = CSR_W'(DIM_RESET);
         errors      = 0;
         checked     = 0;
         frames_done = 0;
      endfunction

      function void set_dim(logic [CSR_W-1:0] value);
         dim_reg = value;
      endfunction

      // one pixel word in; at most one filtered word expected
      function void note_pixel(pixel_type px, logic fs);
         int unsigned   eff, r, c, v, lo_v, hi_v, lo_i, hi_i;
         int unsigned   sum_r, sum_g, sum_b;
         pixel_type     cur[3];
         pixel_type     win[9];
         blur_word_type want;
         eff = dim_reg;
         if (eff < DIM_MIN) eff = DIM_MIN;
         if (eff > MAX_DIM) eff = MAX_DIM;
         r = row_pos;
         c = col_pos;
         if (fs) begin
            r = 0;
            c = 0;
         end
         if (c >= MAX_DIM) c = MAX_DIM - 1;
         cur[0] = two_above_row[c];
         cur[1] = above_row[c];
         cur[2] = px;
         two_above_row[c] = cur[1];
         above_row[c]     = px;
         if (r >= 2 && c >= 2 && r <= eff - 1 && c <= eff - 1) begin
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            lo_v  = 0;
            hi_v  = 0;
            lo_i  = 0;
            hi_i  = 0;
            for (int i = 0; i < 3; i++) begin
               win[i*3]   = prev_cols[0][i];
               win[i*3+1] = prev_cols[1][i];
               win[i*3+2] = cur[i];
            end
            for (int k = 0; k < 9; k++) begin
               v = int'(win[k].red) + int'(win[k].green) + int'(win[k].blue);
               sum_r += win[k].red;
               sum_g += win[k].green;
               sum_b += win[k].blue;
               // min: last on ties, max: first on ties
               if (k == 0 || v <= lo_v) begin
                  lo_v = v;
                  lo_i = k;
               end
               if (k == 0 || v > hi_v) begin
                  hi_v = v;
                  hi_i = k;
               end
            end
            sum_r = sum_r - win[lo_i].red - win[hi_i].red;
            sum_g = sum_g - win[lo_i].green - win[hi_i].green;
            sum_b = sum_b - win[lo_i].blue - win[hi_i].blue;
            want.row   = POS_OUT_W'(r - 1);
            want.col   = POS_OUT_W'(c - 1);
            want.red   = CHAN_W'(sum_r / 7);
            want.green = CHAN_W'(sum_g / 7);
            want.blue  = CHAN_W'(sum_b / 7);
            want.done  = (r == eff - 1 && c == eff - 1);
            pending.push_back(want);
         end
         prev_cols[0] = prev_cols[1];
         prev_cols[1] = cur;
         c++;
         if (c >= eff) begin
            c = 0;
            r++;
            if (r >= eff) r = 0;
         end
         row_pos = r;
         col_pos = c;
      endfunction

      function bit field_ok(string name, logic [15:0] want, logic [15:0] got);
         if (got === want) return 1'b1;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         return 1'b0;
      endfunction

      function void check_word(blur_word_type got);
         blur_word_type want;
         bit            ok;
         if (pending.size() == 0) begin
            $display("%0t: result word with none expected, row %0d col %0d", $time,
                     got.row, got.col);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.done === 1'b1) frames_done++;
         ok = field_ok("out_row", 16'(want.row), 16'(got.row));
         ok &= field_ok("out_col", 16'(want.col), 16'(got.col));
         ok &= field_ok("out_red", 16'(want.red), 16'(got.red));
         ok &= field_ok("out_green", 16'(want.green), 16'(got.green));
         ok &= field_ok("out_blue", 16'(want.blue), 16'(got.blue));
         ok &= field_ok("frame_done", 16'(want.done), 16'(got.done));
         if (!ok) errors++;
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [CHAN_W-1:0]    req_pix_red;
   logic [CHAN_W-1:0]    req_pix_green;
   logic [CHAN_W-1:0]    req_pix_blue;
   logic                 req_frame_start;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [POS_OUT_W-1:0] rsp_out_row;
   logic [POS_OUT_W-1:0] rsp_out_col;
   logic [CHAN_W-1:0]    rsp_out_red;
   logic [CHAN_W-1:0]    rsp_out_green;
   logic [CHAN_W-1:0]    rsp_out_blue;
   logic                 rsp_frame_done;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_W-1:0]     csr_image_dim;

   blur_scoreboard board;
   bit             idle_req;
   bit             idle_rsp;
   int unsigned    pixels_sent;
   int unsigned    word_budget;
   int unsigned    words_in;
   int unsigned    dim_writes;
   int unsigned    quiet;

   trimmed_mean_blur_3x3 DUT (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin : monitor
      blur_word_type got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            board.note_pixel('{blue: req_pix_blue, green: req_pix_green, red: req_pix_red},
                             req_frame_start);
            words_in++;
         end
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_out_row, rsp_out_col, rsp_out_red, rsp_out_green, rsp_out_blue,
                    rsp_frame_done};
            board.check_word(got);
         end
         if (csr_valid && csr_ready) begin
            board.set_dim(csr_image_dim);
            dim_writes++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("%0t: watchdog, no handshake for %0d cycles", $time, quiet);
         $display("testbench NOT OK");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   // result side: random stall before each word while idle_rsp is set
   initial begin
      int unsigned stall;
      rsp_ready = 1'b0;
      forever begin
         stall = idle_rsp ? $urandom_range(0, 12) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1 || reset !== 1'b0);
      end
   end

   function automatic logic [CHAN_W-1:0] palette_level();
      case ($urandom_range(0, 2))
         0: return 8'd0;
         1: return 8'd128;
         default: return 8'd255;
      endcase
   endfunction

   function automatic pixel_type rand_pixel(bit narrow);
      pixel_type p;
      if (narrow) begin
         p.red   = palette_level();
         p.green = palette_level();
         p.blue  = palette_level();
      end else begin
         p = pixel_type'(24'($urandom()));
      end
      return p;
   endfunction

   task automatic send_pixel(pixel_type px, bit fs);
      int unsigned gap;
      gap = idle_req ? $urandom_range(0, 12) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pix_red     <= px.red;
      req_pix_green   <= px.green;
      req_pix_blue    <= px.blue;
      req_frame_start <= fs;
      do @(posedge clock); while (req_ready !== 1'b1);
      pixels_sent++;
   endtask

   // n pixel words, capped by word_budget; fs on the first if lead_fs, plus one-in-noise random fs
   task automatic send_run(int unsigned n, bit lead_fs, bit narrow, int unsigned noise);
      bit fs;
      for (int unsigned i = 0; i < n && pixels_sent < word_budget; i++) begin
         fs = (i == 0) && lead_fs;
         if (noise != 0 && $urandom_range(0, noise - 1) == 0) fs = 1'b1;
         send_pixel(rand_pixel(narrow), fs);
      end
   endtask

   task automatic write_dim(logic [CSR_W-1:0] value);
      csr_valid     <= 1'b1;
      csr_image_dim <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
   endtask

   // drain, then cover words still in flight that give no result
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      pixel_type        px;
      int unsigned      eff;
      int unsigned      pick;
      int unsigned      nf;
      int unsigned      base;
      logic [CSR_W-1:0] dim_val;
      bit               narrow;
      run_kind_type     kind;

      board           = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_pix_red     = '0;
      req_pix_green   = '0;
      req_pix_blue    = '0;
      req_frame_start = 1'b0;
      csr_valid       = 1'b0;
      csr_image_dim   = '0;
      idle_req        = 1'b0;
      idle_rsp        = 1'b0;
      pixels_sent     = 0;
      word_budget     = '1;
      words_in        = 0;
      dim_writes      = 0;
      quiet           = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: 3x3 frames, all black, all white, equal intensities
      write_dim(11'd0);
      for (int k = 0; k < 9; k++) send_pixel(24'h000000, k == 0);
      for (int k = 0; k < 9; k++) send_pixel(24'hFFFFFF, k == 0);
      for (int k = 0; k < 9; k++) begin
         px.red   = 8'(60 + 10 * k);
         px.green = 8'(140 - 10 * k);
         px.blue  = 8'd100;
         send_pixel(px, k == 0);
      end
      settle();

      // full width: one row past the wrap (fills columns 0..19 twice), then shrink mid-frame
      idle_req = 1'b1;
      idle_rsp = 1'b1;
      write_dim(11'h7FF);
      send_run(MAX_DIM + 20, 1'b1, 1'b0, 0);
      settle();
      write_dim(11'd5);
      send_run(31, 1'b0, 1'b1, 0);
      settle();

      base        = pixels_sent;
      word_budget = base + RAND_WORDS;
      while (pixels_sent < word_budget) begin
         pick = $urandom_range(0, 19);
         if (pick < 12) dim_val = 11'($urandom_range(3, 6));
         else if (pick < 16) dim_val = 11'($urandom_range(7, 12));
         else if (pick < 18) dim_val = 11'($urandom_range(0, 2));
         else dim_val = 11'($urandom_range(13, 20));
         eff = (dim_val < DIM_MIN) ? DIM_MIN : dim_val;
         idle_req = $urandom_range(0, 2) != 0;
         idle_rsp = $urandom_range(0, 2) != 0;
         narrow   = $urandom_range(0, 3) == 0;
         pick     = $urandom_range(0, 9);
         if (pick < 6) kind = RUN_FRAMES;
         else if (pick < 8) kind = RUN_RESTART;
         else if (pick < 9) kind = RUN_CONTINUE;
         else kind = RUN_NOISY;
         write_dim(dim_val);
         case (kind)
            RUN_FRAMES: begin
               nf = (eff > 12) ? 1 : $urandom_range(1, 3);
               for (int f = 0; f < nf; f++)
                  send_run(eff * eff, f == 0 || $urandom_range(0, 1) == 1, narrow, 0);
            end
            RUN_RESTART: begin
               send_run($urandom_range(1, eff * eff - 1), 1'b1, narrow, 0);
               send_run(eff * eff, 1'b1, narrow, 0);
            end
            RUN_CONTINUE: send_run($urandom_range(1, 2 * eff * eff), 1'b0, narrow, 0);
            default: send_run($urandom_range(1, 3 * eff * eff), $urandom_range(0, 1) == 1,
                              narrow, 8);
         endcase
         settle();
      end

      $display("Streamed %0d pixel words under %0d image_dim writes (3 up to 1024 wide).",
               words_in, dim_writes);
      $display("Checked %0d filtered words, %0d of them closing a frame.",
               board.checked, board.frames_done);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
